>>> hdl/rvq_pkg.sv
// Shared types, constants and helpers for the rotation-vector to quaternion block.
package rvq_pkg;

  localparam int POS_W   = 24;
  localparam int ROT_W   = 18;
  localparam int QUAT_W  = 16;
  localparam int LIM_W   = 11;
  localparam int ANG_W   = 18;
  localparam int SUM_W   = 36;
  localparam int SQ_W    = 37;
  localparam int PH_W    = 32;
  localparam int QB      = 16;
  localparam int STEPS   = 5;
  localparam int SQRT_STEPS = 18;

  localparam logic [28:0] PHASE_K     = 29'd341782638;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  // Horner divisors and their 2^32 reciprocals (rounded down)
  localparam logic [6:0] SIN_DIV [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_DIV [5] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [31:0] SIN_RCP [4] = '{
    32'(64'h1_0000_0000 / 64'd72), 32'(64'h1_0000_0000 / 64'd42),
    32'(64'h1_0000_0000 / 64'd20), 32'(64'h1_0000_0000 / 64'd6)};
  localparam logic [31:0] COS_RCP [5] = '{
    32'(64'h1_0000_0000 / 64'd90), 32'(64'h1_0000_0000 / 64'd56),
    32'(64'h1_0000_0000 / 64'd30), 32'(64'h1_0000_0000 / 64'd12),
    32'(64'h1_0000_0000 / 64'd2)};

  // sincos pipeline: 3 entry stages plus 3 per Horner step
  localparam int SC_LAT = 3 + 3 * STEPS;

  typedef struct packed {
    logic                    inv;
    logic signed [ROT_W-1:0] rot_z;
    logic signed [ROT_W-1:0] rot_y;
    logic signed [ROT_W-1:0] rot_x;
    logic [POS_W-1:0]        pos_z;
    logic [POS_W-1:0]        pos_y;
    logic [POS_W-1:0]        pos_x;
  } pose_sb_t;

  typedef struct packed {
    pose_sb_t         base;
    logic [ANG_W-1:0] ang;
    logic             small_ang;
  } ang_sb_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_z;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
    logic             inv;
    logic             small_ang;
    logic             neg_x;
    logic [30:0]      qw_mag;
    logic             qw_neg;
  } div_sb_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } sc_carry_t;

  // signed magnitude to saturated 16-bit two's complement
  function automatic logic [QUAT_W-1:0] rvq_sat(input logic [31:0] mag, input logic neg);
    logic signed [33:0] v;
    v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    if (v > 34'sd32767) return 16'h7FFF;
    else if (v < -34'sd32768) return 16'h8000;
    else return v[QUAT_W-1:0];
  endfunction

endpackage

>>> hdl/rvq_sincos.sv
// Pipelined sine/cosine of a 32-bit phase by Horner polynomial evaluation.
module rvq_sincos #(
  parameter int SBW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [31:0]        phase,
  input  logic [SBW-1:0]     in_sb,
  output logic               out_vld,
  output logic signed [31:0] sn,
  output logic signed [31:0] cs,
  output logic [SBW-1:0]     out_sb
);
  import rvq_pkg::*;

  localparam int NST = 3 * STEPS;

  logic [SC_LAT-1:0] vp;
  logic [SBW-1:0]    sbp [SC_LAT];

  logic [1:0]  q1;
  logic        sw1;
  logic [29:0] g1;
  sc_carry_t   c2, c3;
  sc_carry_t   carry [NST];

  logic [30:0] va_s [STEPS];
  logic [30:0] va_c [STEPS];
  logic [30:0] vb_s [STEPS];
  logic [30:0] vb_c [STEPS];
  logic [30:0] qb_s [STEPS];
  logic [30:0] qb_c [STEPS];
  logic [30:0] t_s  [STEPS];
  logic [30:0] t_c  [STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[SC_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbp[0] <= in_sb;
      for (int i = 1; i < SC_LAT; i++) sbp[i] <= sbp[i-1];
    end
  end

  // fold phase into the first octant
  always_ff @(posedge clk) begin
    if (en) begin
      q1  <= phase[31:30];
      sw1 <= phase[29];
      g1  <= phase[29] ? 30'(ONE_Q30 - {1'b0, phase[29:0]}) : phase[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2.x    <= 30'((61'(g1) * 61'(HALF_PI_Q30)) >> 30);
      c2.x2   <= '0;
      c2.quad <= q1;
      c2.swap <= sw1;
      c3.x    <= c2.x;
      c3.quad <= c2.quad;
      c3.swap <= c2.swap;
      c3.x2   <= 30'((60'(c2.x) * 60'(c2.x)) >> 30);
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    sc_carry_t   cin;
    logic [30:0] ts_in, tc_in;
    logic [37:0] rem_s, rem_c;

    if (k == 0) begin : g_first
      assign cin   = c3;
      assign ts_in = ONE_Q30;
      assign tc_in = ONE_Q30;
    end else begin : g_next
      assign cin   = carry[3*k-1];
      assign ts_in = t_s[k-1];
      assign tc_in = t_c[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        carry[3*k]   <= cin;
        carry[3*k+1] <= carry[3*k];
        carry[3*k+2] <= carry[3*k+1];
      end
    end

    // multiply stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (k < STEPS - 1) begin
          va_s[k] <= 31'((61'(cin.x2) * 61'(ts_in)) >> 30);
        end else begin
          va_s[k] <= 31'((61'(cin.x) * 61'(ts_in)) >> 30);
        end
        va_c[k] <= 31'((61'(cin.x2) * 61'(tc_in)) >> 30);
      end
    end

    // reciprocal estimate, low by at most one
    if (k < STEPS - 1) begin : g_sin_div
      always_ff @(posedge clk) begin
        if (en) begin
          qb_s[k] <= 31'((63'(va_s[k]) * 63'(SIN_RCP[k])) >> 32);
        end
      end
      assign rem_s = 38'(vb_s[k]) - 38'(qb_s[k]) * 38'(SIN_DIV[k]);
      always_ff @(posedge clk) begin
        if (en) begin
          t_s[k] <= ONE_Q30 - (qb_s[k] + 31'(rem_s >= 38'(SIN_DIV[k])));
        end
      end
    end else begin : g_sin_out
      always_ff @(posedge clk) begin
        if (en) begin
          qb_s[k] <= '0;
          t_s[k]  <= vb_s[k];
        end
      end
      assign rem_s = 38'(qb_s[k]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vb_s[k] <= va_s[k];
        vb_c[k] <= va_c[k];
        qb_c[k] <= 31'((63'(va_c[k]) * 63'(COS_RCP[k])) >> 32);
        t_c[k]  <= ONE_Q30 - (qb_c[k] + 31'(rem_c >= 38'(COS_DIV[k])));
      end
    end
    assign rem_c = 38'(vb_c[k]) - 38'(qb_c[k]) * 38'(COS_DIV[k]);
  end

  // undo octant swap, then place in quadrant
  logic signed [31:0] s_f, c_f;
  sc_carry_t          cl;
  assign cl = carry[NST-1];
  always_comb begin
    if (cl.swap) begin
      s_f = $signed({1'b0, t_c[STEPS-1]});
      c_f = $signed({1'b0, t_s[STEPS-1]});
    end else begin
      s_f = $signed({1'b0, t_s[STEPS-1]});
      c_f = $signed({1'b0, t_c[STEPS-1]});
    end
    case (cl.quad)
      2'd0:    begin sn = s_f;  cs = c_f;  end
      2'd1:    begin sn = c_f;  cs = -s_f; end
      2'd2:    begin sn = -s_f; cs = -c_f; end
      default: begin sn = -c_f; cs = s_f;  end
    endcase
  end

  assign out_vld = vp[SC_LAT-1];
  assign out_sb  = sbp[SC_LAT-1];

endmodule

>>> hdl/rvq_rdiv.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rvq_rdiv #(
  parameter int NW  = 50,
  parameter int DW  = 36,
  parameter int QBW = 16,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  num,
  input  logic [DW-1:0]  den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [QBW-1:0] quo,
  output logic           ovf,
  output logic [SBW-1:0] out_sb
);
  localparam int RW = (NW > DW + QBW) ? NW : DW + QBW;

  logic [RW-1:0]  rem [QBW+1];
  logic [DW-1:0]  dd  [QBW+1];
  logic [QBW-1:0] qv  [QBW+1];
  logic           of  [QBW+1];
  logic [SBW-1:0] sb  [QBW+1];
  logic [QBW:0]   vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[QBW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num);
      dd[0]  <= den;
      qv[0]  <= '0;
      of[0]  <= (RW+1)'(num) >= ((RW+1)'(den) << QBW);
      sb[0]  <= in_sb;
    end
  end

  for (genvar j = 1; j <= QBW; j++) begin : g_bit
    logic [RW:0] trial;
    assign trial = (RW+1)'(dd[j-1]) << (QBW - j);
    always_ff @(posedge clk) begin
      if (en) begin
        dd[j] <= dd[j-1];
        of[j] <= of[j-1];
        sb[j] <= sb[j-1];
        if ({1'b0, rem[j-1]} >= trial) begin
          rem[j] <= RW'({1'b0, rem[j-1]} - trial);
          qv[j]  <= qv[j-1] | (QBW'(1) << (QBW - j));
        end else begin
          rem[j] <= rem[j-1];
          qv[j]  <= qv[j-1];
        end
      end
    end
  end

  assign out_vld = vp[QBW];
  assign quo     = qv[QBW];
  assign ovf     = of[QBW];
  assign out_sb  = sb[QBW];

endmodule

>>> hdl/pose_rotvec_to_quaternion.sv
// Top level: pose with rotation vector in, pose with unit quaternion out.
//
// Usage
//   Slave stream carries one pose word per handshake; master stream returns
//   one word per accepted input, in order. The invert flag rides on s_tuser.
//   cfg channel writes small_angle_limit (raw angle, ANGLE_FRAC_BITS frac);
//   it is always ready and should be written only while the block is idle.
// Throughput / stages
//   One word per cycle sustained unless the output stalls (see Stall);
//   the whole datapath is a single enable-gated pipeline:
//   squares (2), square root 1 bit/stage (18), phase multiply (1),
//   sine/cosine Horner pipeline (18), products (2), three parallel
//   dividers 1 quotient bit/stage (17), saturation/output register (1).
// Reset
//   rst clears all valid bits and reloads small_angle_limit with 1.
// Stall
//   When m_tready is low with a word waiting, every stage holds and
//   s_tready drops in the same cycle; nothing is dropped or duplicated.
module pose_rotvec_to_quaternion #(
  parameter int ANGLE_FRAC_BITS = 14,
  parameter int QUAT_FRAC_BITS  = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], rot_x[89:72], rot_y[107:90],
  // rot_z[125:108], zero pad [127:126]
  input  logic [127:0]              s_tdata,
  // invert[0]
  input  logic [0:0]                s_tuser,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // out_pos_x[23:0], out_pos_y[47:24], out_pos_z[71:48], quat_x[87:72],
  // quat_y[103:88], quat_z[119:104], quat_w[135:120]
  output logic [135:0]              m_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [rvq_pkg::LIM_W-1:0] cfg_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready
);
  import rvq_pkg::*;

  localparam int SH     = 30 - QUAT_FRAC_BITS;
  localparam int PPW    = ANGLE_FRAC_BITS + 32;
  localparam int NW     = ((49 > ANG_W + SH) ? 49 : ANG_W + SH) + 1;
  localparam int DW     = ANG_W + SH + 1;
  localparam int QW_LIM = (QUAT_FRAC_BITS >= 15) ? 32768 : (1 << QUAT_FRAC_BITS);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // config register
  logic [LIM_W-1:0] small_angle_limit;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      small_angle_limit <= LIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      small_angle_limit <= cfg_data;
    end
  end

  pose_sb_t in_pose;
  assign in_pose.pos_x = s_tdata[23:0];
  assign in_pose.pos_y = s_tdata[47:24];
  assign in_pose.pos_z = s_tdata[71:48];
  assign in_pose.rot_x = s_tdata[89:72];
  assign in_pose.rot_y = s_tdata[107:90];
  assign in_pose.rot_z = s_tdata[125:108];
  assign in_pose.inv   = s_tuser[0];

  // squares, then their sum
  logic              v0, v1;
  pose_sb_t          sb0, sb1;
  logic [SUM_W-1:0]  sq_x, sq_y, sq_z, sum1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb0  <= in_pose;
      sq_x <= SUM_W'(36'(in_pose.rot_x) * 36'(in_pose.rot_x));
      sq_y <= SUM_W'(36'(in_pose.rot_y) * 36'(in_pose.rot_y));
      sq_z <= SUM_W'(36'(in_pose.rot_z) * 36'(in_pose.rot_z));
      sb1  <= sb0;
      sum1 <= sq_x + sq_y + sq_z;
    end
  end

  // integer square root, one result bit per stage
  logic [SQ_W-1:0] sq_v [SQRT_STEPS];
  logic [SQ_W-1:0] sq_r [SQRT_STEPS];
  pose_sb_t        sq_sb [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sq_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= '0;
    end else if (en) begin
      sq_vld <= {sq_vld[SQRT_STEPS-2:0], v1};
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQ_W-1:0] vin, rin, trial;
    pose_sb_t        sbin;
    if (k == 0) begin : g_first
      assign vin  = SQ_W'(sum1);
      assign rin  = '0;
      assign sbin = sb1;
    end else begin : g_next
      assign vin  = sq_v[k-1];
      assign rin  = sq_r[k-1];
      assign sbin = sq_sb[k-1];
    end
    assign trial = rin + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_sb[k] <= sbin;
        if (vin >= trial) begin
          sq_v[k] <= vin - trial;
          sq_r[k] <= (rin >> 1) + BIT;
        end else begin
          sq_v[k] <= vin;
          sq_r[k] <= rin >> 1;
        end
      end
    end
  end

  logic [ANG_W-1:0] ang;
  assign ang = sq_r[SQRT_STEPS-1][ANG_W-1:0];

  // half angle phase in 2^-32 turn, small angle decision
  logic        v20;
  ang_sb_t     sb20;
  logic [31:0] phase20;

  always_ff @(posedge clk) begin
    if (rst) begin
      v20 <= 1'b0;
    end else if (en) begin
      v20 <= sq_vld[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb20.base      <= sq_sb[SQRT_STEPS-1];
      sb20.ang       <= ang;
      sb20.small_ang <= (ang == '0) || (ang < ANG_W'(small_angle_limit));
      phase20        <= 32'((PPW'(ang) * PPW'(PHASE_K)) >> ANGLE_FRAC_BITS);
    end
  end

  logic               vsc;
  logic signed [31:0] sn, cs;
  ang_sb_t            sbsc;

  rvq_sincos #(
    .SBW ($bits(ang_sb_t))
  ) u_sincos (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v20),
    .phase   (phase20),
    .in_sb   (sb20),
    .out_vld (vsc),
    .sn      (sn),
    .cs      (cs),
    .out_sb  (sbsc)
  );

  // vector products and rounded scalar
  logic               vp1, vp2;
  ang_sb_t            sbp1;
  logic signed [49:0] pp_x, pp_y, pp_z;
  logic [30:0]        qw_mag;
  logic               qw_neg;
  logic [30:0]        cs_mag;
  assign cs_mag = cs[31] ? 31'(-cs) : cs[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
      vp2 <= 1'b0;
    end else if (en) begin
      vp1 <= vsc;
      vp2 <= vp1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbp1   <= sbsc;
      pp_x   <= 50'(sbsc.base.rot_x) * 50'(sn);
      pp_y   <= 50'(sbsc.base.rot_y) * 50'(sn);
      pp_z   <= 50'(sbsc.base.rot_z) * 50'(sn);
      qw_mag <= 31'((32'(cs_mag) + (32'(1) << (SH - 1))) >> SH);
      qw_neg <= cs[31];
    end
  end

  // rounding divide: (2|n| + d) / (2d), d = angle << SH
  logic [NW-1:0] n_x, n_y, n_z;
  logic [DW-1:0] d2;
  div_sb_t       dsb;
  logic          neg_y, neg_z;
  logic [48:0]   mag_x, mag_y, mag_z;
  assign mag_x = pp_x[49] ? 49'(-pp_x) : pp_x[48:0];
  assign mag_y = pp_y[49] ? 49'(-pp_y) : pp_y[48:0];
  assign mag_z = pp_z[49] ? 49'(-pp_z) : pp_z[48:0];

  always_ff @(posedge clk) begin
    if (en) begin
      n_x           <= (NW'(mag_x) << 1) + (NW'(sbp1.ang) << SH);
      n_y           <= (NW'(mag_y) << 1) + (NW'(sbp1.ang) << SH);
      n_z           <= (NW'(mag_z) << 1) + (NW'(sbp1.ang) << SH);
      d2            <= DW'(sbp1.ang) << (SH + 1);
      dsb.pos_x     <= sbp1.base.pos_x;
      dsb.pos_y     <= sbp1.base.pos_y;
      dsb.pos_z     <= sbp1.base.pos_z;
      dsb.inv       <= sbp1.base.inv;
      dsb.small_ang <= sbp1.small_ang;
      dsb.neg_x     <= pp_x[49];
      dsb.qw_mag    <= qw_mag;
      dsb.qw_neg    <= qw_neg;
      neg_y         <= pp_y[49];
      neg_z         <= pp_z[49];
    end
  end

  logic          vd;
  logic [QB-1:0] q_x, q_y, q_z;
  logic          of_x, of_y, of_z;
  div_sb_t       dsb_o;
  logic          neg_y_o, neg_z_o;

  rvq_rdiv #(.NW(NW), .DW(DW), .QBW(QB), .SBW($bits(div_sb_t))) u_div_x (
    .clk (clk), .rst (rst), .en (en), .in_vld (vp2),
    .num (n_x), .den (d2), .in_sb (dsb),
    .out_vld (vd), .quo (q_x), .ovf (of_x), .out_sb (dsb_o)
  );

  logic vd_y, vd_z;

  rvq_rdiv #(.NW(NW), .DW(DW), .QBW(QB), .SBW(1)) u_div_y (
    .clk (clk), .rst (rst), .en (en), .in_vld (vp2),
    .num (n_y), .den (d2), .in_sb (neg_y),
    .out_vld (vd_y), .quo (q_y), .ovf (of_y), .out_sb (neg_y_o)
  );

  rvq_rdiv #(.NW(NW), .DW(DW), .QBW(QB), .SBW(1)) u_div_z (
    .clk (clk), .rst (rst), .en (en), .in_vld (vp2),
    .num (n_z), .den (d2), .in_sb (neg_z),
    .out_vld (vd_z), .quo (q_z), .ovf (of_z), .out_sb (neg_z_o)
  );

  // sign, invert, saturate; small angle forces identity
  logic [31:0] m_x, m_y, m_z;
  assign m_x = of_x ? 32'h0001_0000 : 32'(q_x);
  assign m_y = of_y ? 32'h0001_0000 : 32'(q_y);
  assign m_z = of_z ? 32'h0001_0000 : 32'(q_z);

  logic [POS_W-1:0]  o_px, o_py, o_pz;
  logic [QUAT_W-1:0] o_qx, o_qy, o_qz, o_qw;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_px <= dsb_o.pos_x;
      o_py <= dsb_o.pos_y;
      o_pz <= dsb_o.pos_z;
      if (dsb_o.small_ang) begin
        o_qx <= '0;
        o_qy <= '0;
        o_qz <= '0;
        o_qw <= rvq_sat(32'(1 << QUAT_FRAC_BITS), dsb_o.inv);
      end else begin
        o_qx <= rvq_sat(m_x, dsb_o.neg_x ^ dsb_o.inv);
        o_qy <= rvq_sat(m_y, neg_y_o ^ dsb_o.inv);
        o_qz <= rvq_sat(m_z, neg_z_o ^ dsb_o.inv);
        o_qw <= rvq_sat(32'(dsb_o.qw_mag), dsb_o.qw_neg ^ dsb_o.inv);
      end
    end
  end

  assign m_tdata = {o_qw, o_qz, o_qy, o_qx, o_pz, o_py, o_px};

  // lanes of the three dividers run in lockstep
  a_lanes_aligned : assert property (@(posedge clk) disable iff (rst)
    (vd == vd_y) && (vd == vd_z))
    else $error("divider lanes out of step");

  // input is only held off by a stalled output word
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // scalar part never exceeds one in magnitude
  a_qw_bound : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (($signed(m_tdata[135:120]) <= QW_LIM) &&
                  ($signed(m_tdata[135:120]) >= -QW_LIM)))
    else $error("quat_w out of range");

endmodule
